// ===== design/rpt_pkg.sv =====
`default_nettype none

package rpt_pkg;

	localparam int RB_W = 9;
	localparam int SC_W = 12;
	localparam int SYM_W = 14;
	localparam int SYMIDX_W = 4;
	localparam int ELEM_W = 12;
	localparam int USED_W = 3;
	localparam int SC_PER_RB = 12;
	localparam int SYMBOLS = 14;

	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 8;

	localparam int F_BEGIN_LSB = 0;
	localparam int F_END_LSB = 9;
	localparam int F_STRIDE_LSB = 18;
	localparam int F_SC_LSB = 27;
	localparam int F_SYM_LSB = 39;
	localparam int F_SYMIDX_LSB = 53;
	localparam int F_ELEM_LSB = 57;

	// reciprocal of 3 scaled by 2**11, exact for 10-bit dividends
	localparam int RECIP3 = 683;
	localparam int RECIP3_SHIFT = 11;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_MERGE   = 2'd1,
		OP_COLLIDE = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_COLLISION = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic advance;
		logic clear_table;
		logic merge_write;
		logic append;
		logic set_hit;
		logic set_full;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic skip;
		logic empty;
		logic hit;
		logic last;
		logic full;
		logic out_busy;
	} stat_t;

endpackage

`default_nettype wire

// ===== design/re_pattern_table.sv =====
// Throughput: one item at a time; a scan reads one table entry per cycle.
// The next item is taken while the previous result still waits in the output register.
// Reset: arst_n clears the entry count and control state; table contents stay undefined.
`default_nettype none

module re_pattern_table #(
	parameter int TABLE_ENTRIES = 4,
	parameter int MAX_BLOCKS = 275
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// new_rb_begin, new_rb_end, new_rb_stride, new_sc_mask, new_symbol_mask,
	// symbol_index, element_index
	input  wire logic [71:0] s_tdata,
	// opcode
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status, is_masked, entries_used
	output logic [7:0]       m_tdata
);

	rpt_pkg::cmd_t  cmd;
	rpt_pkg::stat_t stat;

	rpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rpt_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_BLOCKS    (MAX_BLOCKS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

`default_nettype wire

// ===== design/rpt_ctrl.sv =====
`default_nettype none

module rpt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire rpt_pkg::stat_t stat,
	output rpt_pkg::cmd_t      cmd
);

	rpt_pkg::state_t state_q;
	rpt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rpt_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = rpt_pkg::S_SCAN;
				end
			end
			rpt_pkg::S_SCAN: begin
				if (stat.op == rpt_pkg::OP_CLEAR || stat.skip || stat.empty || stat.hit
						|| stat.last) begin
					state_d = rpt_pkg::S_FINISH;
				end
			end
			rpt_pkg::S_FINISH: begin
				if (!stat.out_busy) begin
					state_d = rpt_pkg::S_IDLE;
				end
			end
			default: state_d = rpt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			rpt_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.capture = s_tvalid;
			end
			rpt_pkg::S_SCAN: begin
				if (stat.op == rpt_pkg::OP_CLEAR) begin
					cmd.clear_table = 1'b1;
				end else if (stat.skip) begin
					cmd = '0;
				end else if (!stat.empty && stat.hit) begin
					if (stat.op == rpt_pkg::OP_MERGE) begin
						cmd.merge_write = 1'b1;
					end else begin
						cmd.set_hit = 1'b1;
					end
				end else if (stat.empty || stat.last) begin
					if (stat.op == rpt_pkg::OP_MERGE) begin
						cmd.set_full = stat.full;
						cmd.append = !stat.full;
					end
				end else begin
					cmd.advance = 1'b1;
				end
			end
			rpt_pkg::S_FINISH: begin
				cmd.load_out = !stat.out_busy;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/rpt_datapath.sv =====
`default_nettype none

module rpt_datapath #(
	parameter int TABLE_ENTRIES = 4,
	parameter int MAX_BLOCKS = 275
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [rpt_pkg::IN_DATA_W-1:0]    s_tdata,
	input  wire logic [1:0]                       s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [rpt_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  wire rpt_pkg::cmd_t                    cmd,
	output rpt_pkg::stat_t                        stat
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic [rpt_pkg::RB_W-1:0]  ent_begin_q  [TABLE_ENTRIES];
	logic [rpt_pkg::RB_W-1:0]  ent_end_q    [TABLE_ENTRIES];
	logic [rpt_pkg::RB_W-1:0]  ent_stride_q [TABLE_ENTRIES];
	logic [rpt_pkg::SC_W-1:0]  ent_sc_q     [TABLE_ENTRIES];
	logic [rpt_pkg::SYM_W-1:0] ent_sym_q    [TABLE_ENTRIES];

	logic [CW-1:0] entry_count_q;
	logic [IW-1:0] idx_q;
	rpt_pkg::op_t  op_q;
	logic          hit_q;
	logic          full_q;
	logic          out_valid_q;
	logic [rpt_pkg::OUT_DATA_W-1:0] out_q;

	logic [rpt_pkg::RB_W-1:0]     new_begin_q;
	logic [rpt_pkg::RB_W-1:0]     new_end_q;
	logic [rpt_pkg::RB_W-1:0]     new_stride_q;
	logic [rpt_pkg::SC_W-1:0]     new_sc_q;
	logic [rpt_pkg::SYM_W-1:0]    new_sym_q;
	logic [rpt_pkg::SYMIDX_W-1:0] sym_idx_q;
	logic [rpt_pkg::RB_W-1:0]     rb_q;
	logic [3:0]                   sc_idx_q;

	logic [rpt_pkg::ELEM_W-1:0] elem_in;
	logic [19:0]                rb_prod;
	logic [rpt_pkg::RB_W-1:0]   rb_in;
	logic [rpt_pkg::ELEM_W-1:0] rb_times12;
	logic [rpt_pkg::ELEM_W-1:0] sc_rem;

	logic [rpt_pkg::RB_W-1:0]  cur_begin;
	logic [rpt_pkg::RB_W-1:0]  cur_end;
	logic [rpt_pkg::RB_W-1:0]  cur_stride;
	logic [rpt_pkg::SC_W-1:0]  cur_sc;
	logic [rpt_pkg::SYM_W-1:0] cur_sym;
	logic                      sym_eq;
	logic                      sc_eq;
	logic                      merge_hit;
	logic                      collide_hit;
	logic                      query_hit;
	logic                      masks_empty;
	logic                      query_out_of_range;
	logic [IW-1:0]             wr_idx;
	rpt_pkg::status_t          res_status;
	logic                      res_masked;

	assign elem_in = s_tdata[rpt_pkg::F_ELEM_LSB +: rpt_pkg::ELEM_W];
	assign rb_prod = 20'(elem_in[rpt_pkg::ELEM_W-1:2]) * 20'(rpt_pkg::RECIP3);
	assign rb_in = rb_prod[rpt_pkg::RECIP3_SHIFT +: rpt_pkg::RB_W];
	assign rb_times12 = (rpt_pkg::ELEM_W'(rb_in) << 3) + (rpt_pkg::ELEM_W'(rb_in) << 2);
	assign sc_rem = elem_in - rb_times12;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			new_begin_q <= s_tdata[rpt_pkg::F_BEGIN_LSB +: rpt_pkg::RB_W];
			new_end_q <= s_tdata[rpt_pkg::F_END_LSB +: rpt_pkg::RB_W];
			new_stride_q <= s_tdata[rpt_pkg::F_STRIDE_LSB +: rpt_pkg::RB_W];
			new_sc_q <= s_tdata[rpt_pkg::F_SC_LSB +: rpt_pkg::SC_W];
			new_sym_q <= s_tdata[rpt_pkg::F_SYM_LSB +: rpt_pkg::SYM_W];
			sym_idx_q <= s_tdata[rpt_pkg::F_SYMIDX_LSB +: rpt_pkg::SYMIDX_W];
			rb_q <= rb_in;
			sc_idx_q <= sc_rem[3:0];
		end
	end

	assign cur_begin = ent_begin_q[idx_q];
	assign cur_end = ent_end_q[idx_q];
	assign cur_stride = ent_stride_q[idx_q];
	assign cur_sc = ent_sc_q[idx_q];
	assign cur_sym = ent_sym_q[idx_q];

	assign sym_eq = (cur_sym == new_sym_q);
	assign sc_eq = (cur_sc == new_sc_q);
	assign merge_hit = (cur_begin == new_begin_q) && (cur_end == new_end_q)
		&& (cur_stride == new_stride_q) && (sym_eq || sc_eq);
	assign collide_hit = !(cur_begin > new_end_q || new_begin_q > cur_end)
		&& ((cur_sym & new_sym_q) != '0) && ((cur_sc & new_sc_q) != '0);
	assign query_hit = cur_sym[sym_idx_q] && (rb_q >= cur_begin) && (rb_q < cur_end)
		&& cur_sc[sc_idx_q];

	assign masks_empty = (new_sc_q == '0) || (new_sym_q == '0);
	assign query_out_of_range = (sym_idx_q >= rpt_pkg::SYMIDX_W'(rpt_pkg::SYMBOLS))
		|| (10'(rb_q) >= 10'(MAX_BLOCKS));

	always_comb begin
		stat.op = op_q;
		stat.empty = (entry_count_q == '0);
		stat.last = ((CW'(idx_q) + CW'(1)) == entry_count_q);
		stat.full = (entry_count_q == CW'(TABLE_ENTRIES));
		stat.out_busy = out_valid_q && !m_tready;
		case (op_q)
			rpt_pkg::OP_MERGE: begin
				stat.skip = masks_empty;
				stat.hit = merge_hit;
			end
			rpt_pkg::OP_COLLIDE: begin
				stat.skip = masks_empty;
				stat.hit = collide_hit;
			end
			rpt_pkg::OP_QUERY: begin
				stat.skip = query_out_of_range;
				stat.hit = query_hit;
			end
			default: begin
				stat.skip = 1'b0;
				stat.hit = 1'b0;
			end
		endcase
	end

	assign wr_idx = cmd.append ? entry_count_q[IW-1:0] : idx_q;

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			ent_begin_q[wr_idx] <= new_begin_q;
			ent_end_q[wr_idx] <= new_end_q;
			ent_stride_q[wr_idx] <= new_stride_q;
			ent_sc_q[wr_idx] <= new_sc_q;
			ent_sym_q[wr_idx] <= new_sym_q;
		end else if (cmd.merge_write) begin
			if (sym_eq) begin
				ent_sc_q[wr_idx] <= cur_sc | new_sc_q;
			end else begin
				ent_sym_q[wr_idx] <= cur_sym | new_sym_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			idx_q <= '0;
			op_q <= rpt_pkg::OP_CLEAR;
			hit_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				op_q <= rpt_pkg::op_t'(s_tuser);
				idx_q <= '0;
				hit_q <= 1'b0;
				full_q <= 1'b0;
			end else if (cmd.advance) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.set_hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.set_full) begin
				full_q <= 1'b1;
			end
			if (cmd.clear_table) begin
				entry_count_q <= '0;
			end else if (cmd.append) begin
				entry_count_q <= entry_count_q + CW'(1);
			end
		end
	end

	always_comb begin
		res_masked = (op_q == rpt_pkg::OP_QUERY) && hit_q;
		if (op_q == rpt_pkg::OP_COLLIDE && hit_q) begin
			res_status = rpt_pkg::STATUS_COLLISION;
		end else if (full_q) begin
			res_status = rpt_pkg::STATUS_FULL;
		end else begin
			res_status = rpt_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {2'b00, rpt_pkg::USED_W'(entry_count_q), res_masked, res_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && !m_tready))
		else $error("result loaded over a pending transaction");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.append && cmd.merge_write))
		else $error("append and merge write in the same cycle");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_table |=> entry_count_q == '0)
		else $error("table not empty after clear");

	a_append_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> entry_count_q < CW'(TABLE_ENTRIES))
		else $error("append into a full table");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_re_pattern_table.sv =====
`timescale 1ns / 1ps

module tb_re_pattern_table;

	localparam int TABLE_ENTRIES = 4;
	localparam int MAX_BLOCKS = 275;
	localparam int POOL_N = 3;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		rpt_pkg::op_t                 op;
		logic [rpt_pkg::RB_W-1:0]     rb_first;
		logic [rpt_pkg::RB_W-1:0]     rb_last;
		logic [rpt_pkg::RB_W-1:0]     rb_step;
		logic [rpt_pkg::SC_W-1:0]     sc_mask;
		logic [rpt_pkg::SYM_W-1:0]    sym_mask;
		logic [rpt_pkg::SYMIDX_W-1:0] sym_idx;
		logic [rpt_pkg::ELEM_W-1:0]   elem_idx;
	} re_item_t;

	typedef struct {
		rpt_pkg::status_t           status;
		logic                       masked;
		logic [rpt_pkg::USED_W-1:0] used;
	} table_reply_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [rpt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]                     s_tuser = rpt_pkg::OP_CLEAR;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [rpt_pkg::OUT_DATA_W-1:0] m_tdata;

	logic [rpt_pkg::RB_W-1:0]   tbl_first [TABLE_ENTRIES];
	logic [rpt_pkg::RB_W-1:0]   tbl_last [TABLE_ENTRIES];
	logic [rpt_pkg::RB_W-1:0]   tbl_step [TABLE_ENTRIES];
	logic [rpt_pkg::SC_W-1:0]   tbl_sc [TABLE_ENTRIES];
	logic [rpt_pkg::SYM_W-1:0]  tbl_sym [TABLE_ENTRIES];
	int                         tbl_count = 0;

	logic [rpt_pkg::RB_W-1:0]   pool_first [POOL_N];
	logic [rpt_pkg::RB_W-1:0]   pool_last [POOL_N];
	logic [rpt_pkg::RB_W-1:0]   pool_step [POOL_N];
	logic [rpt_pkg::SC_W-1:0]   pool_sc [POOL_N];
	logic [rpt_pkg::SYM_W-1:0]  pool_sym [POOL_N];

	table_reply_t      pending_replies [$];
	bit                idle_on = 1'b1;
	int                mismatches = 0;
	int                replies_checked = 0;
	int                op_seen [4] = '{0, 0, 0, 0};
	int                full_seen = 0;
	int                hits_seen = 0;
	int                stall_left = 0;
	int                cycle_count = 0;

	re_pattern_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_BLOCKS(MAX_BLOCKS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (idle_on && stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		table_reply_t want;
		if (m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: %h", m_tdata);
			end else begin
				want = pending_replies.pop_front();
				replies_checked++;
				if (m_tdata[1:0] !== want.status || m_tdata[2] !== want.masked ||
						m_tdata[5:3] !== want.used) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status %0d/%0d masked %0d/%0d used %0d/%0d",
							want.status, m_tdata[1:0], want.masked, m_tdata[2],
							want.used, m_tdata[5:3]);
				end
			end
		end
	end

	function automatic rpt_pkg::status_t merge_pattern(re_item_t it);
		if (it.sc_mask == '0 || it.sym_mask == '0)
			return rpt_pkg::STATUS_OK;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_first[i] != it.rb_first || tbl_last[i] != it.rb_last ||
					tbl_step[i] != it.rb_step)
				continue;
			if (tbl_sym[i] == it.sym_mask) begin
				tbl_sc[i] = tbl_sc[i] | it.sc_mask;
				return rpt_pkg::STATUS_OK;
			end
			if (tbl_sc[i] == it.sc_mask) begin
				tbl_sym[i] = tbl_sym[i] | it.sym_mask;
				return rpt_pkg::STATUS_OK;
			end
		end
		if (tbl_count >= TABLE_ENTRIES)
			return rpt_pkg::STATUS_FULL;
		tbl_first[tbl_count] = it.rb_first;
		tbl_last[tbl_count] = it.rb_last;
		tbl_step[tbl_count] = it.rb_step;
		tbl_sc[tbl_count] = it.sc_mask;
		tbl_sym[tbl_count] = it.sym_mask;
		tbl_count++;
		return rpt_pkg::STATUS_OK;
	endfunction

	function automatic rpt_pkg::status_t find_collision(re_item_t it);
		if (it.sc_mask == '0 || it.sym_mask == '0)
			return rpt_pkg::STATUS_OK;
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_first[i] > it.rb_last || it.rb_first > tbl_last[i])
				continue;
			if ((tbl_sym[i] & it.sym_mask) == '0)
				continue;
			if ((tbl_sc[i] & it.sc_mask) != '0)
				return rpt_pkg::STATUS_COLLISION;
		end
		return rpt_pkg::STATUS_OK;
	endfunction

	function automatic logic element_masked(re_item_t it);
		int rb;
		int sc;
		rb = int'(it.elem_idx) / rpt_pkg::SC_PER_RB;
		sc = int'(it.elem_idx) % rpt_pkg::SC_PER_RB;
		if (it.sym_idx >= rpt_pkg::SYMBOLS || rb >= MAX_BLOCKS)
			return 1'b0;
		for (int i = 0; i < tbl_count; i++) begin
			if (!tbl_sym[i][it.sym_idx])
				continue;
			if (rb < tbl_first[i] || rb >= tbl_last[i])
				continue;
			if (tbl_sc[i][sc])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic table_reply_t apply_to_table(re_item_t it);
		table_reply_t r;
		r.status = rpt_pkg::STATUS_OK;
		r.masked = 1'b0;
		case (it.op)
			rpt_pkg::OP_CLEAR: tbl_count = 0;
			rpt_pkg::OP_MERGE: r.status = merge_pattern(it);
			rpt_pkg::OP_COLLIDE: r.status = find_collision(it);
			default: r.masked = element_masked(it);
		endcase
		r.used = tbl_count[rpt_pkg::USED_W-1:0];
		return r;
	endfunction

	function automatic re_item_t mk(rpt_pkg::op_t op, int b, int e, int s, int sc, int sym,
			int l, int k);
		re_item_t it;
		it.op = op;
		it.rb_first = b[rpt_pkg::RB_W-1:0];
		it.rb_last = e[rpt_pkg::RB_W-1:0];
		it.rb_step = s[rpt_pkg::RB_W-1:0];
		it.sc_mask = sc[rpt_pkg::SC_W-1:0];
		it.sym_mask = sym[rpt_pkg::SYM_W-1:0];
		it.sym_idx = l[rpt_pkg::SYMIDX_W-1:0];
		it.elem_idx = k[rpt_pkg::ELEM_W-1:0];
		return it;
	endfunction

	task automatic send_item(re_item_t it);
		table_reply_t r;
		logic [rpt_pkg::IN_DATA_W-1:0] d;
		d = '0;
		d[rpt_pkg::F_BEGIN_LSB +: rpt_pkg::RB_W] = it.rb_first;
		d[rpt_pkg::F_END_LSB +: rpt_pkg::RB_W] = it.rb_last;
		d[rpt_pkg::F_STRIDE_LSB +: rpt_pkg::RB_W] = it.rb_step;
		d[rpt_pkg::F_SC_LSB +: rpt_pkg::SC_W] = it.sc_mask;
		d[rpt_pkg::F_SYM_LSB +: rpt_pkg::SYM_W] = it.sym_mask;
		d[rpt_pkg::F_SYMIDX_LSB +: rpt_pkg::SYMIDX_W] = it.sym_idx;
		d[rpt_pkg::F_ELEM_LSB +: rpt_pkg::ELEM_W] = it.elem_idx;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= it.op;
		do @(posedge clk); while (!s_tready);
		r = apply_to_table(it);
		pending_replies.push_back(r);
		op_seen[it.op]++;
		if (r.status == rpt_pkg::STATUS_FULL)
			full_seen++;
		if (r.masked)
			hits_seen++;
	endtask

	task automatic refresh_pool(int p);
		int b;
		b = $urandom_range(0, MAX_BLOCKS - 5);
		pool_first[p] = rpt_pkg::RB_W'(b);
		pool_last[p] = rpt_pkg::RB_W'(b + $urandom_range(1, MAX_BLOCKS - b));
		pool_step[p] = rpt_pkg::RB_W'($urandom_range(1, 4));
		if ($urandom_range(0, 9) == 0) begin
			pool_last[p] = rpt_pkg::RB_W'($urandom_range(0, b));
			pool_step[p] = '0;
		end
		pool_sc[p] = rpt_pkg::SC_W'($urandom_range(1, 4095));
		pool_sym[p] = rpt_pkg::SYM_W'($urandom_range(1, 16383));
	endtask

	function automatic re_item_t shaped_item();
		re_item_t it;
		int p;
		int r;
		int rb;
		p = $urandom_range(0, POOL_N - 1);
		r = $urandom_range(0, 99);
		if (r < 7)
			it.op = rpt_pkg::OP_CLEAR;
		else if (r < 40)
			it.op = rpt_pkg::OP_MERGE;
		else if (r < 70)
			it.op = rpt_pkg::OP_COLLIDE;
		else
			it.op = rpt_pkg::OP_QUERY;
		it.rb_first = rpt_pkg::RB_W'($urandom);
		it.rb_last = rpt_pkg::RB_W'($urandom);
		it.rb_step = rpt_pkg::RB_W'($urandom);
		it.sc_mask = rpt_pkg::SC_W'($urandom);
		it.sym_mask = rpt_pkg::SYM_W'($urandom);
		it.sym_idx = rpt_pkg::SYMIDX_W'($urandom);
		it.elem_idx = rpt_pkg::ELEM_W'($urandom);
		if ($urandom_range(0, 9) == 0)
			return it;
		it.rb_first = pool_first[p];
		it.rb_last = pool_last[p];
		it.rb_step = pool_step[p];
		if (it.op == rpt_pkg::OP_COLLIDE && $urandom_range(0, 2) == 0) begin
			it.rb_first = rpt_pkg::RB_W'($urandom_range(0, MAX_BLOCKS));
			it.rb_last = rpt_pkg::RB_W'($urandom_range(0, MAX_BLOCKS));
		end
		case ($urandom_range(0, 5))
			0, 1: it.sc_mask = pool_sc[p];
			2: it.sc_mask = 12'h001 << $urandom_range(0, 11);
			3: it.sc_mask = '0;
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0, 1: it.sym_mask = pool_sym[p];
			2: it.sym_mask = 14'h0001 << $urandom_range(0, 13);
			3: if ($urandom_range(0, 2) == 0) it.sym_mask = '0;
			default: ;
		endcase
		it.sym_idx = ($urandom_range(0, 15) == 0) ? 4'd15
			: rpt_pkg::SYMIDX_W'($urandom_range(0, 13));
		if (pool_last[p] > pool_first[p] && $urandom_range(0, 7) != 0) begin
			rb = $urandom_range(pool_first[p], pool_last[p] - 1);
			if (rb >= MAX_BLOCKS)
				rb = MAX_BLOCKS - 1;
			it.elem_idx = rpt_pkg::ELEM_W'(rb * rpt_pkg::SC_PER_RB
				+ int'($urandom_range(0, 11)));
		end
		return it;
	endfunction

	task automatic test_clear_and_fill();
		send_item(mk(rpt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 1, 2, 1, 0, 16383, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 1, 2, 1, 4095, 0, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 0, 275, 1, 4095, 16383, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 10, 20, 2, 1, 1, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 511, 0, 0, 2048, 8192, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 300, 511, 511, 5, 5, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 7, 8, 3, 6, 6, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 10, 20, 2, 1, 1, 0, 0));
		send_item(mk(rpt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_merge_absorb();
		send_item(mk(rpt_pkg::OP_MERGE, 5, 9, 1, 12'h00f, 14'h0003, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 5, 9, 1, 12'h00f, 14'h0003, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 5, 9, 1, 12'h0f0, 14'h0003, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 5, 9, 1, 12'h0ff, 14'h3000, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 5, 9, 1, 12'h100, 14'h0010, 0, 0));
		send_item(mk(rpt_pkg::OP_MERGE, 5, 9, 2, 12'h0ff, 14'h3003, 0, 0));
	endtask

	task automatic test_collision();
		send_item(mk(rpt_pkg::OP_COLLIDE, 0, 275, 0, 0, 16383, 0, 0));
		send_item(mk(rpt_pkg::OP_COLLIDE, 0, 275, 0, 4095, 0, 0, 0));
		send_item(mk(rpt_pkg::OP_COLLIDE, 6, 7, 0, 12'h001, 14'h0001, 0, 0));
		send_item(mk(rpt_pkg::OP_COLLIDE, 9, 12, 0, 12'h001, 14'h0001, 0, 0));
		send_item(mk(rpt_pkg::OP_COLLIDE, 10, 12, 0, 12'h001, 14'h0001, 0, 0));
		send_item(mk(rpt_pkg::OP_COLLIDE, 0, 4, 0, 12'h001, 14'h0001, 0, 0));
		send_item(mk(rpt_pkg::OP_COLLIDE, 0, 275, 0, 12'he00, 14'h0fe0, 0, 0));
	endtask

	task automatic test_query_edges();
		send_item(mk(rpt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 5 * 12));
		send_item(mk(rpt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 13, 8 * 12 + 7));
		send_item(mk(rpt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 13, 9 * 12));
		send_item(mk(rpt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 14, 5 * 12));
		send_item(mk(rpt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 15, 5 * 12));
		send_item(mk(rpt_pkg::OP_MERGE, 0, 511, 0, 4095, 16383, 0, 0));
		send_item(mk(rpt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 3299));
		send_item(mk(rpt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 3300));
		send_item(mk(rpt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 4, 4095));
	endtask

	task automatic run_shaped(int count);
		re_item_t it;
		for (int n = 0; n < count; n++) begin
			it = shaped_item();
			if (it.op == rpt_pkg::OP_CLEAR)
				refresh_pool($urandom_range(0, POOL_N - 1));
			send_item(it);
		end
	endtask

	task automatic test_random_mix();
		for (int p = 0; p < POOL_N; p++)
			refresh_pool(p);
		run_shaped(650);
	endtask

	task automatic test_random_steady();
		s_tvalid <= 1'b0;
		@(posedge clk);
		idle_on = 1'b0;
		run_shaped(150);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clear_and_fill();
		test_merge_absorb();
		test_collision();
		test_query_edges();
		test_random_mix();
		test_random_steady();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d clear, %0d merge, %0d collision, %0d query transactions",
			op_seen[rpt_pkg::OP_CLEAR], op_seen[rpt_pkg::OP_MERGE],
			op_seen[rpt_pkg::OP_COLLIDE], op_seen[rpt_pkg::OP_QUERY]);
		$display("%0d results checked, %0d table-full, %0d masked hits, %0d mismatches",
			replies_checked, full_seen, hits_seen, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== re_pattern_table.f =====
design/rpt_pkg.sv
design/rpt_ctrl.sv
design/rpt_datapath.sv
design/re_pattern_table.sv
bench/tb_re_pattern_table.sv
